// File: hdl/rlh_pkg.sv
package rlh_pkg;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned BIN_IDX_W = 3;
  localparam int unsigned RUN_CNT_W = 32;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last_sample;
  } in_item_t;

  typedef struct packed {
    logic [BIN_IDX_W-1:0] bin_index;
    logic [RUN_CNT_W-1:0] up_run_count;
    logic [RUN_CNT_W-1:0] down_run_count;
    logic                 last_bin;
  } out_item_t;

endpackage

// File: hdl/run_length_histogram.sv
// channel | direction | handshake            | payload
// --------+-----------+----------------------+---------------------------------
// in_     | input     | in_valid / in_ready  | rlh_pkg::in_item_t  (one sample)
// out_    | output    | out_valid / out_ready| rlh_pkg::out_item_t (one bin)
//
// one sample per cycle unless a last sample stalls, held in the input register while the run state updates
// a last sample copies both histograms to a readout bank and restarts the live counters
// the bank gives RUN_BINS items through the output register, one per cycle out_ready allows
// a further last sample stalls in the input register until the final bin leaves the bank
// rst_n (synchronous) clears run state, histograms, readout control and valid flags
module run_length_histogram #(
  parameter int unsigned RUN_BINS    = 6,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rlh_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output rlh_pkg::out_item_t out_item
);

  localparam int unsigned LEN_W = $clog2(RUN_BINS + 1);
  localparam int unsigned BIN_W = $clog2(RUN_BINS);

  // input register
  logic              in_vld_r;
  rlh_pkg::in_item_t in_r;

  // live run state
  logic [rlh_pkg::SAMPLE_W-1:0] first_r;
  logic [rlh_pkg::SAMPLE_W-1:0] prev_r;
  logic                         in_seq_r;
  logic [LEN_W-1:0]             up_len_r;
  logic [LEN_W-1:0]             dn_len_r;
  logic [COUNT_WIDTH-1:0]       up_hist_r [RUN_BINS];
  logic [COUNT_WIDTH-1:0]       dn_hist_r [RUN_BINS];

  // readout bank
  logic [COUNT_WIDTH-1:0]       snap_up_r [RUN_BINS];
  logic [COUNT_WIDTH-1:0]       snap_dn_r [RUN_BINS];
  logic                         rd_busy_r;
  logic [BIN_W-1:0]             rd_idx_r;

  // output register
  logic               out_vld_r;
  rlh_pkg::out_item_t out_item_r;

  // update logic
  logic [LEN_W-1:0]       up_len_nxt;
  logic [LEN_W-1:0]       dn_len_nxt;
  logic [1:0]             up_inc [RUN_BINS];
  logic [1:0]             dn_inc [RUN_BINS];
  logic [COUNT_WIDTH-1:0] up_hist_nxt [RUN_BINS];
  logic [COUNT_WIDTH-1:0] dn_hist_nxt [RUN_BINS];
  logic [COUNT_WIDTH:0]   up_sum [RUN_BINS];
  logic [COUNT_WIDTH:0]   dn_sum [RUN_BINS];
  logic [rlh_pkg::SAMPLE_W-1:0] first_eff;
  logic [1:0] step_en;
  logic [1:0] step_rise;

  logic rd_move;
  logic rd_last;
  logic bank_free;
  logic proc_fire;
  logic [63:0] up_ext;
  logic [63:0] dn_ext;

  assign rd_move   = rd_busy_r && (!out_vld_r || out_ready);
  assign rd_last   = (rd_idx_r == BIN_W'(RUN_BINS - 1));
  assign bank_free = !rd_busy_r || (rd_move && rd_last);
  // a last sample needs the readout bank, anything else goes straight through
  assign proc_fire = in_vld_r && (!in_r.last_sample || bank_free);
  assign in_ready  = !in_vld_r || proc_fire;

  // first sample of a sequence is its own reference for the cyclic compare
  assign first_eff = in_seq_r ? first_r : in_r.sample;
  // step 0: compare with previous sample, step 1: cyclic compare on the last sample
  assign step_en   = {in_r.last_sample, in_seq_r};
  assign step_rise = {in_r.sample > first_eff, in_r.sample > prev_r};

  always_comb begin
    up_len_nxt = up_len_r;
    dn_len_nxt = dn_len_r;
    for (int b = 0; b < RUN_BINS; b++) begin
      up_inc[b] = 2'd0;
      dn_inc[b] = 2'd0;
    end
    for (int k = 0; k < 2; k++) begin
      if (step_en[k]) begin
        if (step_rise[k]) begin
          // rise closes the down run
          for (int b = 0; b < RUN_BINS; b++) begin
            if (dn_len_nxt == LEN_W'(b + 1)) begin
              dn_inc[b] = dn_inc[b] + 2'd1;
            end
          end
          if (up_len_nxt < LEN_W'(RUN_BINS)) begin
            up_len_nxt = up_len_nxt + LEN_W'(1);
          end
          dn_len_nxt = LEN_W'(1);
        end else begin
          // non-rise closes the up run
          for (int b = 0; b < RUN_BINS; b++) begin
            if (up_len_nxt == LEN_W'(b + 1)) begin
              up_inc[b] = up_inc[b] + 2'd1;
            end
          end
          if (dn_len_nxt < LEN_W'(RUN_BINS)) begin
            dn_len_nxt = dn_len_nxt + LEN_W'(1);
          end
          up_len_nxt = LEN_W'(1);
        end
      end
    end
    // saturating bin counters
    for (int b = 0; b < RUN_BINS; b++) begin
      up_sum[b] = {1'b0, up_hist_r[b]} + (COUNT_WIDTH + 1)'(up_inc[b]);
      dn_sum[b] = {1'b0, dn_hist_r[b]} + (COUNT_WIDTH + 1)'(dn_inc[b]);
      up_hist_nxt[b] = up_sum[b][COUNT_WIDTH] ? '1 : up_sum[b][COUNT_WIDTH-1:0];
      dn_hist_nxt[b] = dn_sum[b][COUNT_WIDTH] ? '1 : dn_sum[b][COUNT_WIDTH-1:0];
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      in_r <= in_item;
    end
  end

  // live run state, restarted after a last sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r  <= '0;
      prev_r   <= '0;
      in_seq_r <= 1'b0;
      up_len_r <= LEN_W'(1);
      dn_len_r <= LEN_W'(1);
      for (int b = 0; b < RUN_BINS; b++) begin
        up_hist_r[b] <= '0;
        dn_hist_r[b] <= '0;
      end
    end else if (proc_fire) begin
      if (in_r.last_sample) begin
        first_r  <= '0;
        prev_r   <= '0;
        in_seq_r <= 1'b0;
        up_len_r <= LEN_W'(1);
        dn_len_r <= LEN_W'(1);
        for (int b = 0; b < RUN_BINS; b++) begin
          up_hist_r[b] <= '0;
          dn_hist_r[b] <= '0;
        end
      end else begin
        first_r  <= first_eff;
        prev_r   <= in_r.sample;
        in_seq_r <= 1'b1;
        up_len_r <= up_len_nxt;
        dn_len_r <= dn_len_nxt;
        for (int b = 0; b < RUN_BINS; b++) begin
          up_hist_r[b] <= up_hist_nxt[b];
          dn_hist_r[b] <= dn_hist_nxt[b];
        end
      end
    end
  end

  // readout bank: loaded with the final histograms, drained one bin per move
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_busy_r <= 1'b0;
      rd_idx_r  <= '0;
    end else if (proc_fire && in_r.last_sample) begin
      rd_busy_r <= 1'b1;
      rd_idx_r  <= '0;
    end else if (rd_move) begin
      if (rd_last) begin
        rd_busy_r <= 1'b0;
        rd_idx_r  <= '0;
      end else begin
        rd_idx_r <= rd_idx_r + BIN_W'(1);
      end
    end
    if (proc_fire && in_r.last_sample) begin
      for (int b = 0; b < RUN_BINS; b++) begin
        snap_up_r[b] <= up_hist_nxt[b];
        snap_dn_r[b] <= dn_hist_nxt[b];
      end
    end
  end

  // counters wider than the output field give their low bits
  assign up_ext = 64'(snap_up_r[rd_idx_r]);
  assign dn_ext = 64'(snap_dn_r[rd_idx_r]);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (rd_move) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
    if (rd_move) begin
      out_item_r.bin_index      <= rlh_pkg::BIN_IDX_W'(rd_idx_r);
      out_item_r.up_run_count   <= up_ext[rlh_pkg::RUN_CNT_W-1:0];
      out_item_r.down_run_count <= dn_ext[rlh_pkg::RUN_CNT_W-1:0];
      out_item_r.last_bin       <= rd_last;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

  // a last sample always opens a readout burst
  a_last_loads_bank: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_fire && in_r.last_sample) |=> rd_busy_r && (rd_idx_r == '0))
    else $error("last sample did not start readout");

  // live state restarts after a last sample
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_fire && in_r.last_sample) |=>
      (!in_seq_r && (up_len_r == LEN_W'(1)) && (dn_len_r == LEN_W'(1))))
    else $error("run state not restarted after last sample");

  // run lengths saturate at the bin count
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    (up_len_r <= LEN_W'(RUN_BINS)) && (dn_len_r <= LEN_W'(RUN_BINS)) &&
    (up_len_r != '0) && (dn_len_r != '0))
    else $error("run length out of range");

  // the final bin of a burst carries the top index
  a_last_bin_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_item_r.last_bin) |->
      (out_item_r.bin_index == rlh_pkg::BIN_IDX_W'(RUN_BINS - 1)))
    else $error("last bin flag on wrong bin");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

class run_hist_scoreboard;
  localparam int unsigned BINS = 6;
  localparam logic [rlh_pkg::RUN_CNT_W-1:0] COUNT_SAT = '1;

  logic [rlh_pkg::SAMPLE_W-1:0]  first_s;
  logic [rlh_pkg::SAMPLE_W-1:0]  prev_s;
  int unsigned                   up_len;
  int unsigned                   down_len;
  logic [rlh_pkg::RUN_CNT_W-1:0] up_hist[BINS];
  logic [rlh_pkg::RUN_CNT_W-1:0] down_hist[BINS];
  bit                            in_seq;
  rlh_pkg::out_item_t            expected_bins[$];
  int unsigned                   errors;

  function new();
    errors = 0;
    clear();
  endfunction

  function void clear();
    first_s  = '0;
    prev_s   = '0;
    up_len   = 1;
    down_len = 1;
    in_seq   = 1'b0;
    for (int k = 0; k < BINS; k++) begin
      up_hist[k]   = '0;
      down_hist[k] = '0;
    end
  endfunction

  // run of len closes into its bin, top bin takes every longer run
  function void close_run(bit up_side, int unsigned len);
    int unsigned idx;
    idx = (len == 0 || len > BINS) ? BINS - 1 : len - 1;
    if (up_side) begin
      if (up_hist[idx] != COUNT_SAT) up_hist[idx]++;
    end else begin
      if (down_hist[idx] != COUNT_SAT) down_hist[idx]++;
    end
  endfunction

  function void step_run(bit rise);
    if (rise) begin
      if (up_len < BINS) up_len++;
      close_run(1'b0, down_len);
      down_len = 1;
    end else begin
      if (down_len < BINS) down_len++;
      close_run(1'b1, up_len);
      up_len = 1;
    end
  endfunction

  function void note_sample(rlh_pkg::in_item_t it);
    rlh_pkg::out_item_t bin;
    if (!in_seq) begin
      first_s = it.sample;
      in_seq  = 1'b1;
    end else begin
      step_run(it.sample > prev_s);
    end
    prev_s = it.sample;
    if (it.last_sample) begin
      // cyclic compare of last against first, then readout and clear
      step_run(it.sample > first_s);
      for (int k = 0; k < BINS; k++) begin
        bin.bin_index      = rlh_pkg::BIN_IDX_W'(k);
        bin.up_run_count   = up_hist[k];
        bin.down_run_count = down_hist[k];
        bin.last_bin       = (k == BINS - 1);
        expected_bins.push_back(bin);
      end
      clear();
    end
  endfunction

  function void check_bin(rlh_pkg::out_item_t got);
    rlh_pkg::out_item_t want;
    if (expected_bins.size() == 0) begin
      errors++;
      $error("unexpected item: bin_index %0d up %0d down %0d last_bin %0d",
             got.bin_index, got.up_run_count, got.down_run_count, got.last_bin);
      return;
    end
    want = expected_bins.pop_front();
    if (got.bin_index !== want.bin_index) begin
      errors++;
      $error("bin_index expected %0d actual %0d", want.bin_index, got.bin_index);
    end
    if (got.up_run_count !== want.up_run_count) begin
      errors++;
      $error("up_run_count expected %0d actual %0d", want.up_run_count, got.up_run_count);
    end
    if (got.down_run_count !== want.down_run_count) begin
      errors++;
      $error("down_run_count expected %0d actual %0d", want.down_run_count,
             got.down_run_count);
    end
    if (got.last_bin !== want.last_bin) begin
      errors++;
      $error("last_bin expected %0d actual %0d", want.last_bin, got.last_bin);
    end
  endfunction

  function int unsigned pending();
    return expected_bins.size();
  endfunction
endclass

module tb_top;

  // run limit, far above the slowest legal run (every item stalled, 6 bins each)
  localparam int unsigned CYCLE_LIMIT = 200000;
  // cycles the receiver holds off while the sender keeps pushing
  localparam int unsigned HOLD_CYCLES = 80;
  // quiet cycles after the last expected bin, to catch stray output
  localparam int unsigned DRAIN_CYCLES = 30;

  // how the next sample relates to the one before it
  typedef enum int {TREND_UP, TREND_DOWN, TREND_FLAT, TREND_NOISE} trend_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  rlh_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_ready;
  rlh_pkg::out_item_t out_item;

  run_hist_scoreboard hist_sb;
  int unsigned        cycle_count = 0;
  int unsigned        items_sent  = 0;
  // idling switches for each side, and the long receiver hold-off request
  bit                 tx_idle_on  = 1'b1;
  bit                 rx_idle_on  = 1'b1;
  bit                 hold_req    = 1'b0;

  run_length_histogram u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // 12 ns clock, starts low so time zero has no rising edge
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // watchdog: a hang ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // handshake monitors; values seen here are the ones from before the edge
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) hist_sb.note_sample(in_item);
    if (rst_n && out_valid && out_ready) hist_sb.check_bin(out_item);
  end

  // receiver: random ready bursts and stalls, plus one long hold-off on request
  initial begin : receiver
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // next sample follows a trend that changes now and then, so that runs
  // longer than the top bin, ties and wraparound all show up
  function automatic logic [rlh_pkg::SAMPLE_W-1:0] next_sample(
      input logic [rlh_pkg::SAMPLE_W-1:0] prev, inout trend_t trend);
    logic [rlh_pkg::SAMPLE_W-1:0] delta;
    if ($urandom_range(0, 4) == 0) trend = trend_t'($urandom_range(0, 3));
    delta = $urandom_range(1, 4096);
    case (trend)
      TREND_UP:   return prev + delta;
      TREND_DOWN: return prev - delta;
      TREND_FLAT: return ($urandom_range(0, 1) != 0) ? prev : prev + delta;
      default:    return $urandom();
    endcase
  endfunction

  // offer one item, with an optional idle burst in front; returns at the
  // edge where it was taken, valid stays up for a following item
  task automatic send_item(input logic [rlh_pkg::SAMPLE_W-1:0] value, input logic last);
    int unsigned gap;
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_item.sample      <= value;
    in_item.last_sample <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // one sequence of len samples with random start and trend
  task automatic send_sequence(input int unsigned len);
    logic [rlh_pkg::SAMPLE_W-1:0] value;
    trend_t                       trend;
    value = $urandom();
    trend = trend_t'($urandom_range(0, 3));
    for (int unsigned k = 0; k < len; k++) begin
      if (k != 0) value = next_sample(value, trend);
      send_item(value, k == len - 1);
    end
  endtask

  // mostly short sequences, now and then a long one
  task automatic send_random(input int unsigned target);
    while (items_sent < target) begin
      if ($urandom_range(0, 7) == 0) send_sequence($urandom_range(13, 30));
      else send_sequence($urandom_range(1, 12));
    end
  endtask

  task automatic wait_all_bins();
    while (hist_sb.pending() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    hist_sb = new();
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: one-sample sequences at both extremes (self compare is a non-rise)
    send_item(32'h0000_0000, 1'b1);
    send_item(32'hFFFF_FFFF, 1'b1);
    // rise then a cyclic rise of last over first
    send_item(32'h0000_0000, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b1);
    // ties count as non-rises
    send_item(32'd5, 1'b0);
    send_item(32'd5, 1'b0);
    send_item(32'd5, 1'b1);
    // up run past the top bin, saturating the run length
    for (int unsigned k = 1; k <= 9; k++) send_item(k, k == 9);
    // down run from the top value to zero, cyclic compare is a non-rise
    for (int unsigned k = 0; k < 8; k++) begin
      send_item((k == 7) ? 32'h0 : 32'hFFFF_FFFF - k, k == 7);
    end

    // random part with idling on both sides
    send_random(items_sent + 150);

    // back pressure: receiver holds off while short sequences keep coming,
    // so the readout bank and the input register fill and in_ready drops
    tx_idle_on = 1'b0;
    hold_req   = 1'b1;
    while (items_sent < 210 || hold_req) send_sequence($urandom_range(1, 2));
    tx_idle_on = 1'b1;

    // sender pause until every bin has come out
    in_valid <= 1'b0;
    wait_all_bins();
    @(posedge clk);

    send_random(items_sent + 180);

    // last part with no idling at all
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_random(items_sent + 80);
    in_valid <= 1'b0;

    wait_all_bins();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (hist_sb.errors == 0 && hist_sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
